/* hdl/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, register indexes and helpers for the barometric pressure pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_AC1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AC2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AC3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AC4 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TSCALE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TCURVE = 3'd7;

	localparam logic signed [31:0] C_4000 = 32'sd4000;
	localparam logic signed [31:0] C_3791 = 32'sd3791;
	localparam logic signed [31:0] C_3038 = 32'sd3038;
	localparam logic signed [31:0] C_M7357 = -32'sd7357;
	localparam logic [31:0] C_50000 = 32'd50000;
	localparam logic [31:0] C_32768 = 32'd32768;

	// numerator magnitude of the temperature divide: |MC * 2048| < 2^27
	localparam int D1_N = 27;
	localparam int D2_N = 32;

	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [15:0] raw_temperature;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] pressure_pa;
		logic divide_error;
	} out_word_t;

	// truncating signed divide by 2^k
	function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] a, input int k);
		logic [31:0] bias;
		logic [31:0] sum;
		bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
		sum = $unsigned(a) + bias;
		return $signed(sum) >>> k;
	endfunction

	// one restoring divide step: {quotient bit, new remainder}
	function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
		input logic [31:0] d);
		logic [32:0] trial;
		logic [32:0] diff;
		trial = {rem, nb};
		diff = trial - {1'b0, d};
		if (trial >= {1'b0, d}) begin
			return {1'b1, diff[31:0]};
		end else begin
			return {1'b0, trial[31:0]};
		end
	endfunction

endpackage

`default_nettype wire

/* hdl/barometric_pressure_compensation.sv */
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer pressure compensation, one sample pair in, one pressure word out.
// ----------------------------------------------------------------------------
//  channel  signals                        word
//  in       in_valid / in_stall / in_word   raw_pressure, raw_temperature
//  out      out_valid / out_stall / out_word pressure_pa, divide_error
//  cfg      cfg_we / cfg_index / cfg_data    calibration registers 0..7
//
//  One word per cycle while the output word is not stalled; the pipe is
//  the two bit-per-stage dividers (27 stages for the temperature term, 32 for the
//  final sensitivity divide) plus 15 arithmetic stages.
//  Reset clears only the valid bits and the calibration registers.
//  The whole pipe advances together; it holds only when the output word is
//  valid and stalled, and then in_stall is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation #(
	parameter int OVERSAMPLING = 3
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire bpc_pkg::in_word_t          in_word,
	output logic                            out_valid,
	input  wire                             out_stall,
	output bpc_pkg::out_word_t              out_word,
	input  wire                             cfg_we,
	input  wire [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [bpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bpc_pkg::*;

	localparam int UP_SH = 8 - OVERSAMPLING;
	localparam logic [31:0] B7_MUL = C_50000 >> OVERSAMPLING;

	typedef struct packed {
		logic [23:0] up;
		logic signed [31:0] x1;
		logic [31:0] dmag;
		logic [D1_N-1:0] n;
		logic [31:0] rem;
		logic [D1_N-1:0] q;
		logic neg;
		logic err;
	} d1_t;

	typedef struct packed {
		logic [31:0] dmag;
		logic [31:0] n;
		logic [31:0] rem;
		logic [31:0] q;
		logic big;
		logic err;
	} d2_t;

	// calibration registers
	logic signed [15:0] ac1_q, ac2_q, ac3_q, b1_q, b2_q;
	logic [15:0] ac4_q;
	logic [31:0] tscale_q, tcurve_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_q <= '0; ac2_q <= '0; ac3_q <= '0; ac4_q <= '0;
			b1_q <= '0; b2_q <= '0; tscale_q <= '0; tcurve_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AC1: ac1_q <= cfg_data[15:0];
				REG_AC2: ac2_q <= cfg_data[15:0];
				REG_AC3: ac3_q <= cfg_data[15:0];
				REG_AC4: ac4_q <= cfg_data[15:0];
				REG_B1: b1_q <= cfg_data[15:0];
				REG_B2: b2_q <= cfg_data[15:0];
				REG_TSCALE: tscale_q <= cfg_data;
				REG_TCURVE: tcurve_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [16:0] ac5, ac6;
	logic signed [31:0] mc32, md32;
	assign ac5 = {1'b0, tscale_q[31:16]};
	assign ac6 = {1'b0, tscale_q[15:0]};
	assign mc32 = {{16{tcurve_q[31]}}, tcurve_q[31:16]};
	assign md32 = {{16{tcurve_q[15]}}, tcurve_q[15:0]};

	// global advance
	logic en;
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	// s1: (UT - AC6) * AC5
	logic v_s1;
	logic [23:0] up_s1;
	logic signed [31:0] m1_s1;
	logic signed [16:0] t_c;
	assign t_c = $signed({1'b0, in_word.raw_temperature}) - ac6;

	always_ff @(posedge clk) begin
		if (en) begin
			up_s1 <= in_word.raw_pressure >> UP_SH;
			m1_s1 <= 32'(t_c * ac5);
		end
	end

	// s2: X1, divisor X1 + MD, magnitudes for the temperature divide
	logic signed [31:0] x1_c, den_c, num_c;
	logic [31:0] nmag_c, dmag_c;
	always_comb begin
		x1_c = sdiv_p2(m1_s1, 15);
		den_c = x1_c + md32;
		num_c = mc32 <<< 11;
		nmag_c = num_c[31] ? $unsigned(-num_c) : $unsigned(num_c);
		dmag_c = den_c[31] ? $unsigned(-den_c) : $unsigned(den_c);
	end

	d1_t div1_s [0:D1_N];
	logic div1_v [0:D1_N];

	always_ff @(posedge clk) begin
		if (en) begin
			div1_s[0].up <= up_s1;
			div1_s[0].x1 <= x1_c;
			div1_s[0].dmag <= dmag_c;
			div1_s[0].n <= nmag_c[D1_N-1:0];
			div1_s[0].rem <= '0;
			div1_s[0].q <= '0;
			div1_s[0].neg <= num_c[31] ^ den_c[31];
			div1_s[0].err <= (den_c == 32'sd0);
		end
	end

	for (genvar k = 0; k < D1_N; k++) begin : g_div1
		logic [32:0] st;
		d1_t nx;
		assign st = div_step(div1_s[k].rem, div1_s[k].n[D1_N-1], div1_s[k].dmag);
		always_comb begin
			nx = div1_s[k];
			nx.rem = st[31:0];
			nx.n = div1_s[k].n << 1;
			nx.q = {div1_s[k].q[D1_N-2:0], st[32]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div1_s[k+1] <= nx;
			end
		end
	end

	// s3: X2, B5, B6
	logic v_s3;
	logic [23:0] up_s3;
	logic signed [31:0] b6_s3;
	logic err_s3;
	logic signed [31:0] q1_c;
	assign q1_c = $signed({{(32-D1_N){1'b0}}, div1_s[D1_N].q});

	always_ff @(posedge clk) begin
		if (en) begin
			up_s3 <= div1_s[D1_N].up;
			err_s3 <= div1_s[D1_N].err;
			b6_s3 <= div1_s[D1_N].x1 + (div1_s[D1_N].neg ? -q1_c : q1_c) - C_4000;
		end
	end

	// s4: B6 products
	logic v_s4;
	logic [23:0] up_s4;
	logic err_s4;
	logic signed [31:0] sqp_s4, pa2_s4, pa3_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			up_s4 <= up_s3;
			err_s4 <= err_s3;
			sqp_s4 <= 32'(b6_s3 * b6_s3);
			pa2_s4 <= 32'(ac2_q * b6_s3);
			pa3_s4 <= 32'(ac3_q * b6_s3);
		end
	end

	// s5: scale
	logic v_s5;
	logic [23:0] up_s5;
	logic err_s5;
	logic signed [31:0] sq_s5, xa_s5, xc_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			up_s5 <= up_s4;
			err_s5 <= err_s4;
			sq_s5 <= sdiv_p2(sqp_s4, 12);
			xa_s5 <= sdiv_p2(pa2_s4, 11);
			xc_s5 <= sdiv_p2(pa3_s4, 13);
		end
	end

	// s6: quadratic products
	logic v_s6;
	logic [23:0] up_s6;
	logic err_s6;
	logic signed [31:0] xa_s6, xc_s6, pb2_s6, pb1_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			up_s6 <= up_s5;
			err_s6 <= err_s5;
			xa_s6 <= xa_s5;
			xc_s6 <= xc_s5;
			pb2_s6 <= 32'(b2_q * sq_s5);
			pb1_s6 <= 32'(b1_q * sq_s5);
		end
	end

	// s7: X3 sums, B3 before rounding
	logic v_s7;
	logic [23:0] up_s7;
	logic err_s7;
	logic signed [31:0] b3p_s7, x3b_s7;
	logic signed [31:0] sum_b3_c;
	assign sum_b3_c = (32'(ac1_q) <<< 2) + sdiv_p2(pb2_s6, 11) + xa_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			up_s7 <= up_s6;
			err_s7 <= err_s6;
			b3p_s7 <= sum_b3_c <<< OVERSAMPLING;
			x3b_s7 <= sdiv_p2(pb1_s6, 16) + xc_s6 + 32'sd2;
		end
	end

	// s8: B3 and X3 rounding
	logic v_s8;
	logic [23:0] up_s8;
	logic err_s8;
	logic signed [31:0] b3_s8, x3_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			up_s8 <= up_s7;
			err_s8 <= err_s7;
			b3_s8 <= sdiv_p2(b3p_s7 + 32'sd2, 2);
			x3_s8 <= sdiv_p2(x3b_s7, 2);
		end
	end

	// s9: B4 and B7 products
	logic v_s9;
	logic err_s9;
	logic [31:0] b4p_s9, b7_s9;
	always_ff @(posedge clk) begin
		if (en) begin
			err_s9 <= err_s8;
			b4p_s9 <= 32'({16'd0, ac4_q} * ($unsigned(x3_s8) + C_32768));
			b7_s9 <= 32'(({8'd0, up_s8} - $unsigned(b3_s8)) * B7_MUL);
		end
	end

	// s10: load the sensitivity divide
	d2_t div2_s [0:D2_N];
	logic div2_v [0:D2_N];
	logic [31:0] b4_c;
	assign b4_c = b4p_s9 >> 15;

	always_ff @(posedge clk) begin
		if (en) begin
			div2_s[0].dmag <= b4_c;
			div2_s[0].n <= b7_s9[31] ? b7_s9 : (b7_s9 << 1);
			div2_s[0].rem <= '0;
			div2_s[0].q <= '0;
			div2_s[0].big <= b7_s9[31];
			div2_s[0].err <= err_s9 || (b4_c == 32'd0);
		end
	end

	for (genvar k = 0; k < D2_N; k++) begin : g_div2
		logic [32:0] st;
		d2_t nx;
		assign st = div_step(div2_s[k].rem, div2_s[k].n[D2_N-1], div2_s[k].dmag);
		always_comb begin
			nx = div2_s[k];
			nx.rem = st[31:0];
			nx.n = div2_s[k].n << 1;
			nx.q = {div2_s[k].q[D2_N-2:0], st[32]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div2_s[k+1] <= nx;
			end
		end
	end

	// s11: raw pressure
	logic v_s11;
	logic err_s11;
	logic signed [31:0] p_s11, pd_s11;
	logic signed [31:0] pu_c;
	assign pu_c = div2_s[D2_N].big ? $signed(div2_s[D2_N].q << 1) : $signed(div2_s[D2_N].q);

	always_ff @(posedge clk) begin
		if (en) begin
			err_s11 <= div2_s[D2_N].err;
			p_s11 <= pu_c;
			pd_s11 <= sdiv_p2(pu_c, 8);
		end
	end

	// s12: correction products
	logic v_s12;
	logic err_s12;
	logic signed [31:0] p_s12, x1a_s12, x2p_s12;
	always_ff @(posedge clk) begin
		if (en) begin
			err_s12 <= err_s11;
			p_s12 <= p_s11;
			x1a_s12 <= 32'(pd_s11 * pd_s11);
			x2p_s12 <= 32'(C_M7357 * p_s11);
		end
	end

	// s13
	logic v_s13;
	logic err_s13;
	logic signed [31:0] p_s13, x1b_s13, x2_s13;
	always_ff @(posedge clk) begin
		if (en) begin
			err_s13 <= err_s12;
			p_s13 <= p_s12;
			x1b_s13 <= 32'(x1a_s12 * C_3038);
			x2_s13 <= sdiv_p2(x2p_s12, 16);
		end
	end

	// s14
	logic v_s14;
	logic err_s14;
	logic signed [31:0] p_s14, t_s14;
	always_ff @(posedge clk) begin
		if (en) begin
			err_s14 <= err_s13;
			p_s14 <= p_s13;
			t_s14 <= sdiv_p2(x1b_s13, 16) + x2_s13 + C_3791;
		end
	end

	// s15: output register
	logic v_s15;
	out_word_t ow_s15;
	always_ff @(posedge clk) begin
		if (en) begin
			ow_s15.divide_error <= err_s14;
			ow_s15.pressure_pa <= err_s14 ? 32'sd0 : p_s14 + sdiv_p2(t_s14, 4);
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			div1_v[0] <= 1'b0;
			v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			div2_v[0] <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			div1_v[0] <= v_s1;
			v_s3 <= div1_v[D1_N];
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			v_s8 <= v_s7; v_s9 <= v_s8;
			div2_v[0] <= v_s9;
			v_s11 <= div2_v[D2_N];
			v_s12 <= v_s11; v_s13 <= v_s12; v_s14 <= v_s13; v_s15 <= v_s14;
		end
	end

	for (genvar k = 0; k < D1_N; k++) begin : g_v1
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div1_v[k+1] <= 1'b0;
			end else if (en) begin
				div1_v[k+1] <= div1_v[k];
			end
		end
	end

	for (genvar k = 0; k < D2_N; k++) begin : g_v2
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div2_v[k+1] <= 1'b0;
			end else if (en) begin
				div2_v[k+1] <= div2_v[k];
			end
		end
	end

	assign out_valid = v_s15;
	assign out_word = ow_s15;

endmodule

`default_nettype wire

/* hdl/bpc_checker.sv */
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks for the pressure compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             in_valid,
	input wire                             in_stall,
	input wire bpc_pkg::in_word_t          in_word,
	input wire                             out_valid,
	input wire                             out_stall,
	input wire bpc_pkg::out_word_t         out_word,
	input wire                             cfg_we,
	input wire [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input wire [bpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bpc_pkg::*;

	// held word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// a divide fault always forces zero pressure
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.divide_error |-> out_word.pressure_pa == 32'sd0)
		else $error("divide error with nonzero pressure");

	// input is only held back by a stalled output word
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a stalled input word is held by the sender
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_word))
		else $error("input word changed while stalled");

	// calibration writes land on an idle port with known data
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_valid && !out_valid && !$isunknown({cfg_index, cfg_data}))
		else $error("calibration write while words in flight");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);

`default_nettype wire
